>>> rtl/core/dfs_edge_classifier_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Assertion macros for the search block; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef DFS_EDGE_CLASSIFIER_DEFINES_SVH
`define DFS_EDGE_CLASSIFIER_DEFINES_SVH
`ifndef ASSERT_OFF
`define DFS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define DFS_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DFS_ASSERT(label, clk, rst, prop)
`define DFS_ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> rtl/core/dfs_pkg.sv
// ----------------------------------------------------------------------------
// Search block package
// Item types, codes and state encoding for the edge classifier.
// ----------------------------------------------------------------------------
package dfs_pkg;

  localparam int MaxVerticesDef = 16;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_DEL = 2'd1;
  localparam logic [1:0] KIND_RUN = 2'd2;

  localparam logic [1:0] CLS_TREE = 2'd0;
  localparam logic [1:0] CLS_BACK = 2'd1;
  localparam logic [1:0] CLS_FWD = 2'd2;
  localparam logic [1:0] CLS_CROSS = 2'd3;

  localparam logic [1:0] COL_WHITE = 2'd0;
  localparam logic [1:0] COL_GRAY = 2'd1;
  localparam logic [1:0] COL_BLACK = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] from_vertex;
    logic [3:0] to_vertex;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  vertex;
    logic [5:0]  discover_time;
    logic [5:0]  finish_time;
    logic        has_parent;
    logic [3:0]  parent;
    logic [15:0] edge_present;
    logic [31:0] edge_kinds;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/core/dfs_edge_classifier.sv
// ----------------------------------------------------------------------------
// Depth-first search edge classifier
// Holds a 16-vertex directed graph and classifies every edge by a search.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// item      in   start & !busy      in_item_t
// result    out  result_valid       out_item_t
// config    in   cfg_we             cfg_data (vertex_count)
// Add and delete items are applied while idle and can follow back to back.
// A run keeps busy high from acceptance through the root, scan and emit states;
// scan checks one adjacency bit at a time and then finishes the vertex; emit gives
// one result per vertex, each appearing in the cycle after its emit state.
// Reset is synchronous and clears the graph; the receiver cannot stall.
`include "dfs_edge_classifier_defines.svh"
module dfs_edge_classifier #(
  parameter int MAX_VERTICES = dfs_pkg::MaxVerticesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  dfs_pkg::in_item_t  item,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  output logic               result_valid,
  output dfs_pkg::out_item_t result
);

  localparam int VW = (MAX_VERTICES > 16) ? 16 : MAX_VERTICES;

  dfs_pkg::state_t state, state_next;

  logic [15:0] adjacency [16];
  logic [1:0]  color [16];
  logic [5:0]  disc [16];
  logic [5:0]  fin [16];
  logic        par_v [16];
  logic [3:0]  par [16];
  logic [31:0] cls [16];
  logic [3:0]  stk_node [16];
  logic [4:0]  stk_next [16];
  logic [4:0]  sp;
  logic [5:0]  clock_count;
  logic [4:0]  vertex_count;
  logic [4:0]  cnt;
  logic [4:0]  root;
  logic [4:0]  emit_v;

  logic [4:0]  cnt_eff;
  logic [3:0]  u;
  logic [4:0]  t;
  logic [3:0]  t4;
  logic        t_end;
  logic        t_edge;
  logic [5:0]  clk_inc;
  logic [3:0]  ev;
  logic [15:0] mask;
  logic [15:0] pres;
  logic [31:0] kinds;

  always_comb begin
    cnt_eff = vertex_count;
    if (cnt_eff == 5'd0) cnt_eff = 5'd1;
    if (cnt_eff > 5'(VW)) cnt_eff = 5'(VW);
  end

  assign u = stk_node[sp[3:0] - 4'd1];
  assign t = stk_next[sp[3:0] - 4'd1];
  assign t4 = t[3:0];
  assign t_end = (t >= cnt);
  assign t_edge = !t_end && adjacency[u][t4];
  assign clk_inc = clock_count + 6'd1;
  assign busy = (state != dfs_pkg::ST_IDLE);
  assign ev = emit_v[3:0];

  always_comb begin
    state_next = state;
    case (state)
      dfs_pkg::ST_IDLE: begin
        if (start && item.kind == dfs_pkg::KIND_RUN) state_next = dfs_pkg::ST_ROOT;
      end
      dfs_pkg::ST_ROOT: begin
        if (root >= cnt) state_next = dfs_pkg::ST_EMIT;
        else if (color[root[3:0]] == dfs_pkg::COL_WHITE) state_next = dfs_pkg::ST_SCAN;
      end
      dfs_pkg::ST_SCAN: begin
        if (t_end && sp == 5'd1) state_next = dfs_pkg::ST_ROOT;
      end
      dfs_pkg::ST_EMIT: begin
        if (emit_v + 5'd1 >= cnt) state_next = dfs_pkg::ST_IDLE;
      end
      default: state_next = dfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dfs_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) adjacency[i] <= '0;
      vertex_count <= 5'd16;
      sp <= '0;
      clock_count <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == dfs_pkg::ST_EMIT);
      if (cfg_we) vertex_count <= cfg_data;
      case (state)
        dfs_pkg::ST_IDLE: begin
          if (start) begin
            if (item.kind == dfs_pkg::KIND_ADD && 32'(item.from_vertex) < VW &&
                32'(item.to_vertex) < VW)
              adjacency[item.from_vertex][item.to_vertex] <= 1'b1;
            if (item.kind == dfs_pkg::KIND_DEL && 32'(item.from_vertex) < VW &&
                32'(item.to_vertex) < VW)
              adjacency[item.from_vertex][item.to_vertex] <= 1'b0;
            if (item.kind == dfs_pkg::KIND_RUN) begin
              cnt <= cnt_eff;
              root <= '0;
              emit_v <= '0;
              sp <= '0;
              clock_count <= '0;
              for (int i = 0; i < 16; i++) begin
                color[i] <= dfs_pkg::COL_WHITE;
                par_v[i] <= 1'b0;
                par[i] <= '0;
                cls[i] <= '0;
              end
            end
          end
        end
        dfs_pkg::ST_ROOT: begin
          if (root < cnt) begin
            root <= root + 5'd1;
            if (color[root[3:0]] == dfs_pkg::COL_WHITE) begin
              color[root[3:0]] <= dfs_pkg::COL_GRAY;
              clock_count <= clk_inc;
              disc[root[3:0]] <= clk_inc;
              stk_node[0] <= root[3:0];
              stk_next[0] <= '0;
              sp <= 5'd1;
            end
          end
        end
        dfs_pkg::ST_SCAN: begin
          if (t_end) begin
            color[u] <= dfs_pkg::COL_BLACK;
            clock_count <= clk_inc;
            fin[u] <= clk_inc;
            sp <= sp - 5'd1;
          end else begin
            stk_next[sp[3:0] - 4'd1] <= t + 5'd1;
            if (t_edge) begin
              if (color[t4] == dfs_pkg::COL_WHITE) begin
                cls[u][2*t4 +: 2] <= dfs_pkg::CLS_TREE;
                par_v[t4] <= 1'b1;
                par[t4] <= u;
                color[t4] <= dfs_pkg::COL_GRAY;
                clock_count <= clk_inc;
                disc[t4] <= clk_inc;
                if (sp < 5'd16) begin
                  stk_node[sp[3:0]] <= t4;
                  stk_next[sp[3:0]] <= '0;
                  sp <= sp + 5'd1;
                end
              end else if (color[t4] == dfs_pkg::COL_GRAY)
                cls[u][2*t4 +: 2] <= dfs_pkg::CLS_BACK;
              else if (disc[u] < disc[t4])
                cls[u][2*t4 +: 2] <= dfs_pkg::CLS_FWD;
              else
                cls[u][2*t4 +: 2] <= dfs_pkg::CLS_CROSS;
            end
          end
        end
        dfs_pkg::ST_EMIT: begin
          emit_v <= emit_v + 5'd1;
          result.vertex <= ev;
          result.discover_time <= disc[ev];
          result.finish_time <= fin[ev];
          result.has_parent <= par_v[ev];
          result.parent <= par_v[ev] ? par[ev] : 4'd0;
          result.edge_present <= pres;
          result.edge_kinds <= kinds;
          result.last <= (emit_v + 5'd1 == cnt);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mask = 16'((17'd1 << cnt) - 17'd1);
    pres = adjacency[ev] & mask;
    for (int i = 0; i < 16; i++)
      kinds[2*i +: 2] = pres[i] ? cls[ev][2*i +: 2] : 2'b00;
  end

  `DFS_ASSERT(a_sp_bound, clk, rst, sp <= 5'd16)
  `DFS_ASSERT(a_idle_sp, clk, rst, (state == dfs_pkg::ST_IDLE) |-> !busy)
  `DFS_ASSERT(a_res_emit, clk, rst, result_valid |-> $past(state == dfs_pkg::ST_EMIT))
  `DFS_ASSERT(a_scan_sp, clk, rst, (state == dfs_pkg::ST_SCAN) |-> (sp != 5'd0))

endmodule
